FILE: rtl/core/assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// Each expects clk and rst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds on every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/lkvc_pkg.sv
// Package for the LRU key/value cache: widths, codes and sequencer states.
// No dependencies.
package lkvc_pkg;

  localparam int DATA_W      = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESP
  } lkvc_state_t;

endpackage

FILE: rtl/core/lru_key_value_cache.sv
// LRU key/value cache top level: sequencer, key/value/rank memories, valid bits.
// Depends on lkvc_pkg and assert_macros.svh.
//
// Usage:
//  - A request (in_opcode, in_key, in_value_in) is taken on a clock edge with
//    start high and busy low. in_opcode is get or put.
//  - One result (out_found, out_value_out) per request, shown for exactly one
//    cycle with out_valid high. The receiver cannot stall it.
//  - cfg_we writes cfg_capacity_limit; write only while busy is low.
//  - Every request sweeps all ENTRIES slots once through the single read port
//    (key compare, free slot and LRU victim search). A hit or insert then
//    sweeps the rank memory a second time, one read-modify-write per cycle.
//  - A request passes through the search, decide, update (skipped on a get
//    miss) and response states before out_valid.
//  - busy drops in the cycle out_valid is high, so a new request may be taken
//    then; no new request is taken while busy is high.
//  - Synchronous reset clears valid bits, entry count and sequencer and sets
//    the capacity to 16. No memory clearing pass is needed.
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  in_key,
  input  logic signed [lkvc_pkg::DATA_W-1:0]  in_value_in,
  output logic                                out_valid,
  output logic                                out_found,
  output logic signed [lkvc_pkg::DATA_W-1:0]  out_value_out,
  input  logic                                cfg_we,
  input  logic        [lkvc_pkg::CAP_W-1:0]   cfg_capacity_limit
);
  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(ENTRIES);

  lkvc_state_t state_r, state_nxt;

  logic              op_r;
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] val_r;

  logic [CNT_W-1:0]  addr_r, addr_nxt;
  logic              stg_vld_r, stg_vld_nxt;
  logic [IDX_W-1:0]  stg_idx_r, stg_idx_nxt;

  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]  hit_rank_r, hit_rank_nxt;
  logic [DATA_W-1:0] hit_val_r, hit_val_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]  vict_idx_r, vict_idx_nxt;
  logic              ins_r, ins_nxt;
  logic [IDX_W-1:0]  tgt_idx_r, tgt_idx_nxt;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0]   cap_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;

  logic [DATA_W-1:0] key_mem  [ENTRIES];
  logic [DATA_W-1:0] val_mem  [ENTRIES];
  logic [IDX_W-1:0]  rank_mem [ENTRIES];
  logic [DATA_W-1:0] key_rd_r;
  logic [DATA_W-1:0] val_rd_r;
  logic [IDX_W-1:0]  rank_rd_r;

  logic              accept;
  logic              rd_en;
  logic              kv_we;
  logic              val_we;
  logic [IDX_W-1:0]  wr_idx;
  logic              rank_we;
  logic [IDX_W-1:0]  rank_wdata;

  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              evict_c;
  logic [IDX_W-1:0]  slot_c;
  logic              sweep_last;

  assign busy          = (state_r != ST_IDLE);
  assign accept        = start && !busy;
  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_value_out = out_value_r;

  assign cap_ext = CMP_W'(cap_r);
  assign eff_cap = (cap_r == '0) ? CMP_W'(1) :
                   (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign evict_c = (op_r == OP_PUT) && !hit_r && (count_r != '0) &&
                   (CMP_W'(count_r) >= eff_cap);
  assign slot_c  = (evict_c && !(free_r && (free_idx_r < vict_idx_r))) ?
                   vict_idx_r : free_idx_r;
  assign sweep_last = (addr_r == SWEEP_END) && stg_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sweep_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!hit_r && (op_r == OP_GET)) state_nxt = ST_RESP;
        else state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sweep_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    addr_nxt      = addr_r;
    stg_vld_nxt   = 1'b0;
    stg_idx_nxt   = addr_r[IDX_W-1:0];
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_rank_nxt  = hit_rank_r;
    hit_val_nxt   = hit_val_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    vict_idx_nxt  = vict_idx_r;
    ins_nxt       = ins_r;
    tgt_idx_nxt   = tgt_idx_r;
    valid_nxt     = valid_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    rd_en         = 1'b0;
    kv_we         = 1'b0;
    val_we        = 1'b0;
    wr_idx        = tgt_idx_r;
    rank_we       = 1'b0;
    rank_wdata    = rank_rd_r;
    case (state_r)
      ST_IDLE: begin
        addr_nxt     = '0;
        hit_nxt      = 1'b0;
        free_nxt     = 1'b0;
        vict_idx_nxt = '0;
      end
      ST_SEARCH: begin
        rd_en = (addr_r != SWEEP_END);
        if (rd_en) begin
          addr_nxt    = addr_r + CNT_W'(1);
          stg_vld_nxt = 1'b1;
        end
        if (stg_vld_r) begin
          if (valid_r[stg_idx_r]) begin
            if ((key_rd_r == key_r) && !hit_r) begin
              hit_nxt      = 1'b1;
              hit_idx_nxt  = stg_idx_r;
              hit_rank_nxt = rank_rd_r;
              hit_val_nxt  = val_rd_r;
            end
            if (CNT_W'(rank_rd_r) == (count_r - CNT_W'(1))) vict_idx_nxt = stg_idx_r;
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = stg_idx_r;
          end
        end
      end
      ST_DECIDE: begin
        addr_nxt = '0;
        if (hit_r) begin
          ins_nxt     = 1'b0;
          tgt_idx_nxt = hit_idx_r;
          if (op_r == OP_PUT) begin
            val_we = 1'b1;
            wr_idx = hit_idx_r;
          end
        end else if (op_r == OP_PUT) begin
          ins_nxt     = 1'b1;
          tgt_idx_nxt = slot_c;
          kv_we       = 1'b1;
          val_we      = 1'b1;
          wr_idx      = slot_c;
          if (evict_c) valid_nxt[vict_idx_r] = 1'b0;
          valid_nxt[slot_c] = 1'b1;
          count_nxt = evict_c ? count_r : count_r + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        rd_en = (addr_r != SWEEP_END);
        if (rd_en) begin
          addr_nxt    = addr_r + CNT_W'(1);
          stg_vld_nxt = 1'b1;
        end
        if (stg_vld_r) begin
          if (stg_idx_r == tgt_idx_r) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
          end else if (valid_r[stg_idx_r] && (ins_r || (rank_rd_r < hit_rank_r))) begin
            rank_we    = 1'b1;
            rank_wdata = rank_rd_r + IDX_W'(1);
          end
        end
      end
      ST_RESP: begin
        out_valid_nxt = 1'b1;
        out_found_nxt = hit_r;
        out_value_nxt = (hit_r && (op_r == OP_GET)) ? hit_val_r : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      stg_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      ins_r       <= 1'b0;
      valid_r     <= '0;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      stg_vld_r   <= stg_vld_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      ins_r       <= ins_nxt;
      valid_r     <= valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cap_r <= cfg_capacity_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_opcode;
      key_r <= in_key;
      val_r <= in_value_in;
    end
    stg_idx_r   <= stg_idx_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    free_idx_r  <= free_idx_nxt;
    vict_idx_r  <= vict_idx_nxt;
    tgt_idx_r   <= tgt_idx_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (kv_we) key_mem[wr_idx] <= key_r;
    if (rd_en) key_rd_r <= key_mem[addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[wr_idx] <= val_r;
    if (rd_en) val_rd_r <= val_mem[addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[stg_idx_r] <= rank_wdata;
    if (rd_en) rank_rd_r <= rank_mem[addr_r[IDX_W-1:0]];
  end

`include "assert_macros.svh"

  `ASSERT_NEXT(a_out_pulse, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `ASSERT_IMPLIES(a_out_idle, out_valid_r, state_r == ST_IDLE, "result strobe while busy")
  `ASSERT_ALWAYS(a_count_valid, $countones(valid_r) == int'(count_r), "entry count off")
  `ASSERT_NEXT(a_accept, start && !busy, state_r == ST_SEARCH, "request not taken")
  `ASSERT_IMPLIES(a_rank_wr, rank_we, state_r == ST_UPDATE, "rank write outside update")

endmodule
